[design/clbs_pkg.sv]
package clbs_pkg;

	localparam int GLYPH_SLOTS = 8;
	localparam int MAX_DIGITS = 10;
	localparam int NUM_WIDTH = 32;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_WIDTH = 4 * BCD_DIGITS;
	localparam int CNT_WIDTH = $clog2(NUM_WIDTH);
	localparam int QUEUE_DEPTH = 2;
	localparam int ADDR_WIDTH = 5;

	localparam logic [2:0] CMD_INIT = 3'd0;
	localparam logic [2:0] CMD_COMMAND = 3'd1;
	localparam logic [2:0] CMD_CHAR = 3'd2;
	localparam logic [2:0] CMD_GOTO = 3'd3;
	localparam logic [2:0] CMD_GLYPH = 3'd4;
	localparam logic [2:0] CMD_NUMBER = 3'd5;

	localparam logic [2:0] REG_BUS_MODE = 3'd0;
	localparam logic [2:0] REG_SECOND_LINE_BASE = 3'd1;
	localparam logic [2:0] REG_FUNC_SET_8BIT = 3'd2;
	localparam logic [2:0] REG_FUNC_SET_4BIT = 3'd3;
	localparam logic [2:0] REG_DISPLAY_ON = 3'd4;
	localparam logic [2:0] REG_ENTRY_MODE = 3'd5;

	localparam logic [15:0] WAIT_SHORT = 16'd50;
	localparam logic [15:0] WAIT_LONG = 16'd2000;
	localparam logic [15:0] WAIT_POWER_UP = 16'd40000;
	localparam logic [15:0] WAIT_FIRST_WAKE = 16'd5000;
	localparam logic [15:0] WAIT_WAKE = 16'd150;

	localparam logic [7:0] CLEAR_CMD = 8'h01;
	localparam logic [7:0] HOME_CMD = 8'h02;
	localparam logic [7:0] GLYPH_BASE = 8'h40;
	localparam logic [7:0] GOTO_BASE = 8'h80;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] WAKE_NIBBLE = 8'h03;
	localparam logic [7:0] FOUR_BIT_NIBBLE = 8'h02;

	localparam logic [3:0] INIT_POWER = 4'd0;
	localparam logic [3:0] INIT_WAKE_FIRST = 4'd1;
	localparam logic [3:0] INIT_WAKE_LAST = 4'd4;
	localparam logic [3:0] INIT_FUNC = 4'd5;
	localparam logic [3:0] INIT_DISPLAY = 4'd6;
	localparam logic [3:0] INIT_CLEAR = 4'd7;
	localparam logic [3:0] GLYPH_LAST = 4'd8;
	localparam logic [3:0] DIGIT_LAST = 4'(MAX_DIGITS - 1);

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] data_byte;
		logic [1:0] row;
		logic [5:0] column;
		logic [3:0] slot;
		logic [63:0] pattern;
		logic [31:0] number;
	} in_item_t;

	typedef struct packed {
		logic strobe_res;
		logic rs;
		logic [7:0] bus_data;
		logic [15:0] wait_us;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic bus_mode;
		logic [6:0] second_line_base;
		logic [7:0] func_set_8bit_cmd;
		logic [7:0] func_set_4bit_cmd;
		logic [7:0] display_on_cmd;
		logic [7:0] entry_mode_cmd;
	} cfg_t;

	typedef enum logic [1:0] {
		OP_INIT,
		OP_BYTE,
		OP_GLYPH,
		OP_NUMBER
	} op_t;

	typedef struct packed {
		op_t op;
		logic rs;
		logic [7:0] byte_val;
		logic [63:0] payload;
		logic [3:0] start;
	} q_entry_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_PUSH
	} front_state_t;

	typedef enum logic {
		B_IDLE,
		B_RUN
	} back_state_t;

	function automatic logic [15:0] cmd_wait(input logic [7:0] b);
		return (b == CLEAR_CMD || b == HOME_CMD) ? WAIT_LONG : WAIT_SHORT;
	endfunction

endpackage

[design/char_lcd_bus_sequencer.sv]
// Character LCD bus sequencer. Requests enter on the in channel (in_valid,
// in_ready, in_data) and each one expands into a run of bus strobes on the
// out channel (out_valid, out_ready, out_data); the final strobe of a request
// carries last. Requests that produce nothing (unused command codes, glyph
// slots out of range) are taken and dropped.
// The front takes one request at a time and classifies it; a number request
// then passes through a shift-and-add-3 decimal converter, one input bit per
// cycle. A two-entry queue separates the front from the back sequencer.
// Within a request the back emits one strobe per cycle while out_ready is
// high. The first strobe of a request passes through the front's entry
// register, the queue memory and the back's entry and output registers.
// When the receiver stalls, the output register holds its strobe, the back
// waits, the queue fills and the front then lowers in_ready.
// Reset clears all control state and loads the configuration registers with
// their defaults (4-bit bus, line two at address 64). The user must write
// configuration over the APB port only while the block is idle (unenforced).
module char_lcd_bus_sequencer import clbs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_WIDTH-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	cfg_t cfg_q;
	logic cfg_wr;
	logic [2:0] reg_idx;
	logic push_valid, push_ready, pop_valid, pop_ready;
	q_entry_t push_data, pop_data;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_WIDTH-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bus_mode <= 1'b1;
			cfg_q.second_line_base <= 7'd64;
			cfg_q.func_set_8bit_cmd <= 8'd56;
			cfg_q.func_set_4bit_cmd <= 8'd40;
			cfg_q.display_on_cmd <= 8'd12;
			cfg_q.entry_mode_cmd <= 8'd6;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_BUS_MODE: cfg_q.bus_mode <= pwdata[0];
				REG_SECOND_LINE_BASE: cfg_q.second_line_base <= pwdata[6:0];
				REG_FUNC_SET_8BIT: cfg_q.func_set_8bit_cmd <= pwdata[7:0];
				REG_FUNC_SET_4BIT: cfg_q.func_set_4bit_cmd <= pwdata[7:0];
				REG_DISPLAY_ON: cfg_q.display_on_cmd <= pwdata[7:0];
				REG_ENTRY_MODE: cfg_q.entry_mode_cmd <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_BUS_MODE: prdata = 32'(cfg_q.bus_mode);
			REG_SECOND_LINE_BASE: prdata = 32'(cfg_q.second_line_base);
			REG_FUNC_SET_8BIT: prdata = 32'(cfg_q.func_set_8bit_cmd);
			REG_FUNC_SET_4BIT: prdata = 32'(cfg_q.func_set_4bit_cmd);
			REG_DISPLAY_ON: prdata = 32'(cfg_q.display_on_cmd);
			REG_ENTRY_MODE: prdata = 32'(cfg_q.entry_mode_cmd);
			default: prdata = 32'd0;
		endcase
	end

	clbs_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	clbs_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	clbs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

[design/clbs_front.sv]
module clbs_front import clbs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_data,
	output logic push_valid,
	input logic push_ready,
	output q_entry_t push_data
);

	front_state_t state_q, state_nxt;
	q_entry_t ent_q, ent_class;
	logic keep, is_num, accept;
	logic [NUM_WIDTH-1:0] bin_q;
	logic [BCD_WIDTH-1:0] bcd_q, bcd_adj;
	logic [CNT_WIDTH-1:0] cnt_q;
	logic [7:0] goto_addr;
	logic [3:0] num_start;

	assign accept = in_valid && in_ready;

	always_comb begin
		goto_addr = 8'd0;
		if (in_data.row == 2'd0) begin
			goto_addr = {2'b00, in_data.column};
		end else if (in_data.row == 2'd1) begin
			goto_addr = {1'b0, cfg.second_line_base} + {2'b00, in_data.column};
		end
	end

	always_comb begin
		ent_class = '0;
		ent_class.op = OP_BYTE;
		ent_class.payload = in_data.pattern;
		keep = 1'b1;
		is_num = 1'b0;
		unique case (in_data.cmd)
			CMD_INIT: begin
				ent_class.op = OP_INIT;
			end
			CMD_COMMAND: begin
				ent_class.byte_val = in_data.data_byte;
			end
			CMD_CHAR: begin
				ent_class.rs = 1'b1;
				ent_class.byte_val = in_data.data_byte;
			end
			CMD_GOTO: begin
				ent_class.byte_val = GOTO_BASE | goto_addr;
			end
			CMD_GLYPH: begin
				ent_class.op = OP_GLYPH;
				ent_class.byte_val = GLYPH_BASE + {1'b0, in_data.slot, 3'b000};
				keep = ({28'd0, in_data.slot} < 32'(GLYPH_SLOTS));
			end
			CMD_NUMBER: begin
				ent_class.op = OP_NUMBER;
				is_num = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_comb begin
		num_start = DIGIT_LAST;
		for (int p = 0; p < MAX_DIGITS; p++) begin
			if (bcd_q[4*p +: 4] != 4'd0) begin
				num_start = 4'(MAX_DIGITS - 1 - p);
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept && is_num) begin
					state_nxt = F_CONV;
				end else if (accept && keep) begin
					state_nxt = F_PUSH;
				end
			end
			F_CONV: begin
				if (cnt_q == CNT_WIDTH'(NUM_WIDTH - 1)) begin
					state_nxt = F_PUSH;
				end
			end
			F_PUSH: begin
				if (push_ready) begin
					state_nxt = F_IDLE;
				end
			end
			default: begin
				state_nxt = F_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = (state_q == F_IDLE);
		push_valid = (state_q == F_PUSH);
		push_data = ent_q;
		if (ent_q.op == OP_NUMBER) begin
			push_data.payload = 64'(bcd_q);
			push_data.start = num_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == F_CONV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_q <= ent_class;
			bin_q <= in_data.number;
			bcd_q <= '0;
		end else if (state_q == F_CONV) begin
			bcd_q <= {bcd_adj[BCD_WIDTH-2:0], bin_q[NUM_WIDTH-1]};
			bin_q <= {bin_q[NUM_WIDTH-2:0], 1'b0};
		end
	end

endmodule

[design/clbs_queue.sv]
module clbs_queue import clbs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input q_entry_t push_data,
	output logic pop_valid,
	input logic pop_ready,
	output q_entry_t pop_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	q_entry_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[design/clbs_back.sv]
module clbs_back import clbs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic pop_valid,
	output logic pop_ready,
	input q_entry_t pop_data,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_data
);

	back_state_t state_q, state_nxt;
	q_entry_t ent_q;
	logic [3:0] step_q, e_next;
	logic lo_q;
	logic out_valid_q;
	out_item_t out_q, res;
	logic e_raw, e_strobe, e_rs, e_final, split, emit, done;
	logic [7:0] e_val;
	logic [15:0] e_wait;
	logic [2:0] gl_idx;
	logic [3:0] dig_idx;

	assign gl_idx = 3'(step_q - 4'd1);
	assign dig_idx = DIGIT_LAST - step_q;

	always_comb begin
		e_raw = 1'b0;
		e_strobe = 1'b1;
		e_rs = 1'b0;
		e_val = 8'd0;
		e_wait = 16'd0;
		e_final = 1'b0;
		e_next = step_q + 4'd1;
		unique case (ent_q.op)
			OP_BYTE: begin
				e_rs = ent_q.rs;
				e_val = ent_q.byte_val;
				e_wait = ent_q.rs ? WAIT_SHORT : cmd_wait(ent_q.byte_val);
				e_final = 1'b1;
			end
			OP_GLYPH: begin
				if (step_q == 4'd0) begin
					e_val = ent_q.byte_val;
					e_wait = cmd_wait(ent_q.byte_val);
				end else begin
					e_rs = 1'b1;
					e_val = ent_q.payload[{gl_idx, 3'b000} +: 8];
					e_wait = WAIT_SHORT;
				end
				e_final = (step_q == GLYPH_LAST);
			end
			OP_NUMBER: begin
				e_rs = 1'b1;
				e_val = ASCII_ZERO + {4'd0, ent_q.payload[{dig_idx, 2'b00} +: 4]};
				e_wait = WAIT_SHORT;
				e_final = (step_q == DIGIT_LAST);
			end
			OP_INIT: begin
				priority if (step_q == INIT_POWER) begin
					e_raw = 1'b1;
					e_strobe = 1'b0;
					e_wait = WAIT_POWER_UP;
					e_next = cfg.bus_mode ? INIT_WAKE_FIRST : INIT_FUNC;
				end else if (step_q <= INIT_WAKE_LAST) begin
					e_raw = 1'b1;
					e_val = (step_q == INIT_WAKE_LAST) ? FOUR_BIT_NIBBLE : WAKE_NIBBLE;
					e_wait = (step_q == INIT_WAKE_FIRST) ? WAIT_FIRST_WAKE : WAIT_WAKE;
				end else if (step_q == INIT_FUNC) begin
					e_val = cfg.bus_mode ? cfg.func_set_4bit_cmd : cfg.func_set_8bit_cmd;
					e_wait = cmd_wait(e_val) + (cfg.bus_mode ? 16'd0 : WAIT_LONG);
				end else if (step_q == INIT_DISPLAY) begin
					e_val = cfg.display_on_cmd;
					e_wait = cmd_wait(e_val) + WAIT_LONG;
				end else if (step_q == INIT_CLEAR) begin
					e_val = CLEAR_CMD;
					e_wait = cmd_wait(e_val) + WAIT_LONG;
				end else begin
					e_val = cfg.entry_mode_cmd;
					e_wait = cmd_wait(e_val) + WAIT_LONG;
					e_final = 1'b1;
				end
			end
			default: begin
				e_final = 1'b1;
			end
		endcase
	end

	assign split = !e_raw && cfg.bus_mode;
	assign emit = (state_q == B_RUN) && (!out_valid_q || out_ready);
	assign done = e_final && (!split || lo_q);

	always_comb begin
		res.strobe_res = e_strobe;
		res.rs = e_rs;
		if (!split) begin
			res.bus_data = e_val;
		end else if (lo_q) begin
			res.bus_data = {4'd0, e_val[3:0]};
		end else begin
			res.bus_data = {4'd0, e_val[7:4]};
		end
		res.wait_us = (split && !lo_q) ? 16'd0 : e_wait;
		res.last = done;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (pop_valid) begin
					state_nxt = B_RUN;
				end
			end
			B_RUN: begin
				if (emit && done) begin
					state_nxt = B_IDLE;
				end
			end
			default: begin
				state_nxt = B_IDLE;
			end
		endcase
	end

	always_comb begin
		pop_ready = (state_q == B_IDLE);
		out_valid = out_valid_q;
		out_data = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
			step_q <= '0;
			lo_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop_valid && pop_ready) begin
				step_q <= pop_data.start;
				lo_q <= 1'b0;
			end else if (emit) begin
				if (split && !lo_q) begin
					lo_q <= 1'b1;
				end else begin
					lo_q <= 1'b0;
					step_q <= e_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			ent_q <= pop_data;
		end
		if (emit) begin
			out_q <= res;
		end
	end

endmodule

[bench/char_lcd_bus_sequencer_tb.sv]
module char_lcd_bus_sequencer_tb;
	import clbs_pkg::*;

	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;
	localparam int STROBE_CAP = 20;
	localparam int REPORT_LIMIT = 10;
	localparam int SETTLE_CYCLES = 64;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int ITEMS_PER_PHASE = 97;

	class strobe_ledger;
		bit four_bit;
		logic [6:0] line_two_base;
		logic [7:0] init_func8;
		logic [7:0] init_func4;
		logic [7:0] init_display;
		logic [7:0] init_entry;
		out_item_t burst[$];
		out_item_t pending_strobes[$];
		int mismatch_count;

		function new();
			four_bit = 1'b1;
			line_two_base = 7'd64;
			init_func8 = 8'd56;
			init_func4 = 8'd40;
			init_display = 8'd12;
			init_entry = 8'd6;
			mismatch_count = 0;
		endfunction

		function void set_register(logic [2:0] idx, logic [31:0] value);
			case (idx)
				REG_BUS_MODE: four_bit = value[0];
				REG_SECOND_LINE_BASE: line_two_base = value[6:0];
				REG_FUNC_SET_8BIT: init_func8 = value[7:0];
				REG_FUNC_SET_4BIT: init_func4 = value[7:0];
				REG_DISPLAY_ON: init_display = value[7:0];
				REG_ENTRY_MODE: init_entry = value[7:0];
				default: ;
			endcase
		endfunction

		function void add_strobe(bit strobe, bit rs, logic [7:0] data, logic [15:0] hold_us);
			out_item_t s;
			if (burst.size() >= STROBE_CAP)
				return;
			s.strobe_res = strobe;
			s.rs = rs;
			s.bus_data = data;
			s.wait_us = hold_us;
			s.last = 1'b0;
			burst.push_back(s);
		endfunction

		function void add_byte(bit rs, logic [7:0] b, logic [15:0] hold_us);
			if (four_bit) begin
				add_strobe(1'b1, rs, {4'h0, b[7:4]}, 16'd0);
				add_strobe(1'b1, rs, {4'h0, b[3:0]}, hold_us);
			end else begin
				add_strobe(1'b1, rs, b, hold_us);
			end
		endfunction

		function void add_command(logic [7:0] b, logic [15:0] extra_us);
			logic [15:0] hold_us;
			hold_us = (b == CLEAR_CMD || b == HOME_CMD) ? WAIT_LONG : WAIT_SHORT;
			add_byte(1'b0, b, hold_us + extra_us);
		endfunction

		function void take_request(in_item_t r);
			logic [7:0] addr;
			logic [31:0] v;
			logic [7:0] digits[$];
			burst.delete();
			case (r.cmd)
				CMD_INIT: begin
					add_strobe(1'b0, 1'b0, 8'h00, WAIT_POWER_UP);
					if (four_bit) begin
						add_strobe(1'b1, 1'b0, WAKE_NIBBLE, WAIT_FIRST_WAKE);
						add_strobe(1'b1, 1'b0, WAKE_NIBBLE, WAIT_WAKE);
						add_strobe(1'b1, 1'b0, WAKE_NIBBLE, WAIT_WAKE);
						add_strobe(1'b1, 1'b0, FOUR_BIT_NIBBLE, WAIT_WAKE);
						add_command(init_func4, 16'd0);
					end else begin
						add_command(init_func8, WAIT_LONG);
					end
					add_command(init_display, WAIT_LONG);
					add_command(CLEAR_CMD, WAIT_LONG);
					add_command(init_entry, WAIT_LONG);
				end
				CMD_COMMAND: add_command(r.data_byte, 16'd0);
				CMD_CHAR: add_byte(1'b1, r.data_byte, WAIT_SHORT);
				CMD_GOTO: begin
					if (r.row == 2'd0)
						addr = {2'b00, r.column};
					else if (r.row == 2'd1)
						addr = 8'({1'b0, line_two_base} + {2'b00, r.column});
					else
						addr = 8'h00;
					add_command(GOTO_BASE | addr, 16'd0);
				end
				CMD_GLYPH: begin
					if (r.slot < GLYPH_SLOTS) begin
						add_command(8'(GLYPH_BASE + r.slot * 8), 16'd0);
						for (int k = 0; k < 8; k++)
							add_byte(1'b1, r.pattern[8*k +: 8], WAIT_SHORT);
					end
				end
				CMD_NUMBER: begin
					v = r.number;
					do begin
						digits.push_front(8'(v % 10) + ASCII_ZERO);
						v = v / 10;
					end while (v != 0 && digits.size() < MAX_DIGITS);
					foreach (digits[k])
						add_byte(1'b1, digits[k], WAIT_SHORT);
				end
				default: ;
			endcase
			if (burst.size() > 0)
				burst[burst.size()-1].last = 1'b1;
			foreach (burst[k])
				pending_strobes.push_back(burst[k]);
		endfunction

		function void log_failure(string what);
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("%t: %s", $realtime, what);
		endfunction

		function string describe(out_item_t s);
			return $sformatf("strobe=%0b rs=%0b data=%02h wait=%0d last=%0b",
				s.strobe_res, s.rs, s.bus_data, s.wait_us, s.last);
		endfunction

		function void check_strobe(out_item_t got);
			out_item_t want;
			if (pending_strobes.size() == 0) begin
				log_failure({"unexpected strobe: ", describe(got)});
				return;
			end
			want = pending_strobes.pop_front();
			if (got.strobe_res !== want.strobe_res || got.rs !== want.rs ||
					got.bus_data !== want.bus_data || got.wait_us !== want.wait_us ||
					got.last !== want.last)
				log_failure({"strobe mismatch: expected ", describe(want),
					", got ", describe(got)});
		endfunction

		function void report_missing();
			while (pending_strobes.size() > 0)
				log_failure({"missing strobe: ", describe(pending_strobes.pop_front())});
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_WIDTH-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	strobe_ledger ledger;
	int send_idle_pct;
	int stall_pct;
	int quiet_cycles;

	char_lcd_bus_sequencer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				ledger.check_strobe(out_data);
			if (in_valid && in_ready)
				ledger.take_request(in_data);
			if ((out_valid && out_ready) || (in_valid && in_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	function automatic in_item_t scrambled(logic [2:0] code);
		in_item_t r;
		r.cmd = code;
		r.data_byte = 8'($urandom);
		r.row = 2'($urandom);
		r.column = 6'($urandom);
		r.slot = 4'($urandom);
		r.pattern = {$urandom, $urandom};
		r.number = $urandom;
		return r;
	endfunction

	function automatic logic [7:0] pick_command_byte();
		case ($urandom_range(4))
			0: return CLEAR_CMD;
			1: return HOME_CMD;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_number();
		logic [31:0] p;
		p = 32'd1;
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(999);
			2: begin
				repeat ($urandom_range(9)) p = p * 10;
				return p - $urandom_range(1);
			end
			default: return 32'hFFFF_FFFF - $urandom_range(10);
		endcase
	endfunction

	function automatic in_item_t random_request();
		in_item_t r;
		if ($urandom_range(99) < 4)
			r = scrambled($urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B);
		else
			r = scrambled(3'($urandom_range(CMD_NUMBER)));
		if ($urandom_range(99) < 30)
			r.data_byte = pick_command_byte();
		if ($urandom_range(99) < 85)
			r.slot = 4'($urandom_range(GLYPH_SLOTS - 1));
		else
			r.slot = 4'($urandom_range(15, GLYPH_SLOTS));
		r.number = pick_number();
		return r;
	endfunction

	task automatic push_request(input in_item_t req);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_outputs();
		in_valid <= 1'b0;
		while (ledger.pending_strobes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_WIDTH'({idx, 2'b00});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		ledger.set_register(idx, value);
	endtask

	task automatic apply_settings(input bit bus, input logic [6:0] base, input logic [7:0] f8,
			input logic [7:0] f4, input logic [7:0] disp, input logic [7:0] entry);
		write_register(REG_BUS_MODE, {31'd0, bus});
		write_register(REG_SECOND_LINE_BASE, {25'd0, base});
		write_register(REG_FUNC_SET_8BIT, {24'd0, f8});
		write_register(REG_FUNC_SET_4BIT, {24'd0, f4});
		write_register(REG_DISPLAY_ON, {24'd0, disp});
		write_register(REG_ENTRY_MODE, {24'd0, entry});
	endtask

	task automatic run_directed();
		in_item_t r;
		push_request(scrambled(CMD_INIT));
		r = scrambled(CMD_COMMAND);
		r.data_byte = CLEAR_CMD;
		push_request(r);
		r.data_byte = HOME_CMD;
		push_request(r);
		r.data_byte = 8'h00;
		push_request(r);
		r.data_byte = 8'hFF;
		push_request(r);
		r = scrambled(CMD_CHAR);
		r.data_byte = 8'h00;
		push_request(r);
		r.data_byte = 8'hFF;
		push_request(r);
		r = scrambled(CMD_GOTO);
		r.row = 2'd0;
		r.column = 6'd0;
		push_request(r);
		r.column = 6'd63;
		push_request(r);
		r.row = 2'd1;
		push_request(r);
		r.row = 2'd2;
		r.column = 6'd5;
		push_request(r);
		r.row = 2'd3;
		r.column = 6'd63;
		push_request(r);
		r = scrambled(CMD_GLYPH);
		r.slot = 4'd0;
		r.pattern = '1;
		push_request(r);
		r.slot = 4'(GLYPH_SLOTS - 1);
		r.pattern = '0;
		push_request(r);
		r.slot = 4'(GLYPH_SLOTS);
		push_request(r);
		r.slot = 4'd15;
		push_request(r);
		r = scrambled(CMD_NUMBER);
		r.number = 32'd0;
		push_request(r);
		r.number = 32'd9;
		push_request(r);
		r.number = 32'd10;
		push_request(r);
		r.number = 32'd1_000_000_000;
		push_request(r);
		r.number = 32'hFFFF_FFFF;
		push_request(r);
		push_request(scrambled(CMD_SPARE_A));
		push_request(scrambled(CMD_SPARE_B));
	endtask

	initial begin
		int idle_plan[4];
		int stall_plan[4];
		idle_plan = '{0, 65, 0, 31};
		stall_plan = '{0, 0, 65, 31};
		ledger = new();
		quiet_cycles = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_plan[p];
			stall_pct = stall_plan[p];
			case (p)
				0: run_directed();
				1: begin
					drain_outputs();
					apply_settings(1'b0, 7'd127, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
				end
				2: begin
					drain_outputs();
					apply_settings(1'b1, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00);
				end
				default: begin
					drain_outputs();
					apply_settings($urandom_range(1), 7'($urandom_range(127)),
						pick_command_byte(), pick_command_byte(),
						pick_command_byte(), pick_command_byte());
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n == ITEMS_PER_PHASE / 2) begin
					drain_outputs();
					write_register(REG_BUS_MODE, {31'd0, ~ledger.four_bit});
				end
				push_request(random_request());
			end
		end

		drain_outputs();
		ledger.report_missing();
		if (ledger.mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
